[rtl/swr_pkg.sv]
// Shared types and fixed sizes for the signed window scalar recoder.
// No dependencies; used by every module in rtl/.
package swr_pkg;

  localparam int SCALAR_W = 256;
  localparam int CHUNK_W  = 64;
  localparam int DIGIT_W  = 16;
  localparam int POS_W    = 2;
  localparam int EXT_W    = 32;

  localparam logic [POS_W-1:0] POS_FIRST = 2'd0;
  localparam logic [POS_W-1:0] POS_LAST  = 2'd3;

  typedef logic [CHUNK_W-1:0] chunk_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] window_digit;
    logic               last_of_chunk;
    logic               last_of_scalar;
  } swr_result_t;

endpackage

[rtl/swr_in_buf.sv]
// Input request register for scalar chunks.
// Depends on swr_pkg.
module swr_in_buf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  swr_pkg::chunk_t in_chunk,
  output logic            buf_valid,
  output swr_pkg::chunk_t buf_chunk,
  input  logic            buf_take
);

  logic            valid_r, valid_nxt;
  swr_pkg::chunk_t chunk_r;
  logic            load;

  assign in_stall  = valid_r && !buf_take;
  assign load      = in_valid && !in_stall;
  assign buf_valid = valid_r;
  assign buf_chunk = chunk_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (buf_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      chunk_r <= in_chunk;
    end
  end

endmodule

[rtl/swr_core.sv]
// Window sequencer/datapath: one signed digit per cycle unless stalled.
// Depends on swr_pkg.
module swr_core #(
  parameter int WINDOW_BITS  = 16,
  parameter int WINDOW_COUNT = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 buf_valid,
  input  swr_pkg::chunk_t      buf_chunk,
  output logic                 buf_take,
  input  logic                 slot_free,
  output logic                 res_emit,
  output swr_pkg::swr_result_t res
);

  localparam int FIT    = (swr_pkg::SCALAR_W - 1 + WINDOW_BITS) / WINDOW_BITS;
  localparam int TOTAL  = (WINDOW_COUNT < FIT) ? WINDOW_COUNT : FIT;
  localparam int LAST_LO = (TOTAL - 1) * WINDOW_BITS;
  localparam int LAST_WD = swr_pkg::SCALAR_W - LAST_LO;
  localparam int LAST_N  = (LAST_WD < swr_pkg::EXT_W) ? LAST_WD : swr_pkg::EXT_W;
  localparam int JW     = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int LOW    = 8;
  localparam int CMPW   = 10;
  localparam int PAIR_W = 2 * swr_pkg::CHUNK_W;
  localparam int OFF_W  = $clog2(PAIR_W);

  localparam logic [JW-1:0]   J_LAST = JW'(TOTAL - 1);
  localparam logic [JW-1:0]   J_PREV = JW'(TOTAL - 2);
  localparam logic [CMPW-1:0] WB_C   = CMPW'(WINDOW_BITS);

  logic                         busy_r, busy_nxt;
  logic [swr_pkg::POS_W-1:0]    pos_r, pos_nxt;
  logic [JW-1:0]                j_r, j_nxt;
  logic [LOW-1:0]               lo_r, lo_nxt;
  logic                         carry_r, carry_nxt;
  swr_pkg::chunk_t              cur_r, prev_r;
  logic [swr_pkg::SCALAR_W-1:0] full_r;

  logic                         is_last, can_emit, next_ok, finish;
  logic [CMPW-1:0]              lim, lo_end, lo_end2;
  logic [PAIR_W-1:0]            pair, shifted;
  logic [OFF_W-1:0]             off;
  logic [WINDOW_BITS:0]         nl_sum;
  logic [WINDOW_BITS-1:0]       nl_digit;
  logic [LAST_N:0]              last_sum;
  logic [swr_pkg::EXT_W-1:0]    nl_ext, last_ext;

  assign is_last = (j_r == J_LAST);
  assign lim     = CMPW'({1'b0, pos_r} + 3'd1) << 6;
  assign lo_end  = CMPW'(lo_r) + WB_C;
  assign lo_end2 = lo_end + WB_C;

  always_comb begin
    if (is_last) begin
      can_emit = (pos_r == swr_pkg::POS_LAST);
      next_ok  = 1'b0;
    end else begin
      can_emit = (lo_end <= lim);
      next_ok  = (j_r == J_PREV) ? (pos_r == swr_pkg::POS_LAST) : (lo_end2 <= lim);
    end
  end

  // window sits in the previous or the current chunk
  assign pair     = {cur_r, prev_r};
  assign off      = {lo_r[7:6] == pos_r, lo_r[5:0]};
  assign shifted  = pair >> off;
  assign nl_sum   = {1'b0, shifted[WINDOW_BITS-1:0]} + (WINDOW_BITS+1)'(carry_r);
  assign nl_digit = nl_sum[WINDOW_BITS-1:0];
  assign nl_ext   = swr_pkg::EXT_W'(nl_digit);

  assign last_sum = {1'b0, full_r[LAST_LO +: LAST_N]} + (LAST_N+1)'(carry_r);
  assign last_ext = swr_pkg::EXT_W'(last_sum[LAST_N-1:0]);

  assign res_emit = busy_r && can_emit && slot_free;
  assign finish   = busy_r && (!can_emit || (res_emit && !next_ok));
  assign buf_take = buf_valid && (!busy_r || finish);

  always_comb begin
    res.window_digit   = is_last ? last_ext[swr_pkg::DIGIT_W-1:0]
                                 : nl_ext[swr_pkg::DIGIT_W-1:0];
    res.last_of_chunk  = !next_ok;
    res.last_of_scalar = is_last;
  end

  always_comb begin
    busy_nxt  = busy_r;
    pos_nxt   = pos_r;
    j_nxt     = j_r;
    lo_nxt    = lo_r;
    carry_nxt = carry_r;
    if (res_emit) begin
      j_nxt     = j_r + JW'(1);
      lo_nxt    = lo_r + LOW'(WINDOW_BITS);
      carry_nxt = !is_last && (nl_sum[WINDOW_BITS] || nl_digit[WINDOW_BITS-1]);
    end
    if (finish) begin
      busy_nxt = 1'b0;
      if (pos_r == swr_pkg::POS_LAST) begin
        pos_nxt   = swr_pkg::POS_FIRST;
        j_nxt     = '0;
        lo_nxt    = '0;
        carry_nxt = 1'b0;
      end else begin
        pos_nxt = pos_r + 2'd1;
      end
    end
    if (buf_take) begin
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      pos_r   <= swr_pkg::POS_FIRST;
      j_r     <= '0;
      lo_r    <= '0;
      carry_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      pos_r   <= pos_nxt;
      j_r     <= j_nxt;
      lo_r    <= lo_nxt;
      carry_r <= carry_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (buf_take) begin
      cur_r  <= buf_chunk;
      prev_r <= cur_r;
      full_r[pos_nxt*swr_pkg::CHUNK_W +: swr_pkg::CHUNK_W] <= buf_chunk;
    end
  end

endmodule

[rtl/swr_out_reg.sv]
// Result register for window digit requests.
// Depends on swr_pkg.
module swr_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 res_emit,
  input  swr_pkg::swr_result_t res,
  output logic                 slot_free,
  output logic                 out_valid,
  input  logic                 out_stall,
  output swr_pkg::swr_result_t out_res
);

  logic                 valid_r, valid_nxt;
  swr_pkg::swr_result_t res_r;

  assign slot_free = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (slot_free) begin
      valid_nxt = res_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_emit && slot_free) begin
      res_r <= res;
    end
  end

endmodule

[rtl/signed_window_scalar_recoder_unit.sv]
// Signed window scalar recoder: 64-bit chunks in, at most one window digit per cycle out.
// A chunk passes the input register into the core; its digits are registered onto out_.
// Throughput: one digit per cycle while chunks arrive and out_stall is low; a chunk
// holds the sequencer until it has emitted each window it completes (4 at 16-bit windows).
// Reset (rst_n low, synchronous) empties both registers and clears carry and positions.
// Depends on swr_pkg, swr_in_buf, swr_core and swr_out_reg.
module signed_window_scalar_recoder_unit #(
  parameter int WINDOW_BITS  = 16,
  parameter int WINDOW_COUNT = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [swr_pkg::CHUNK_W-1:0] in_scalar_chunk,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [swr_pkg::DIGIT_W-1:0] out_window_digit,
  output logic                        out_last_of_chunk,
  output logic                        out_last_of_scalar
);

  logic                 buf_valid, buf_take, slot_free, res_emit;
  swr_pkg::chunk_t      buf_chunk;
  swr_pkg::swr_result_t res, out_res;

  swr_in_buf u_in_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_chunk  (in_scalar_chunk),
    .buf_valid (buf_valid),
    .buf_chunk (buf_chunk),
    .buf_take  (buf_take)
  );

  swr_core #(
    .WINDOW_BITS  (WINDOW_BITS),
    .WINDOW_COUNT (WINDOW_COUNT)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .buf_valid (buf_valid),
    .buf_chunk (buf_chunk),
    .buf_take  (buf_take),
    .slot_free (slot_free),
    .res_emit  (res_emit),
    .res       (res)
  );

  swr_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_emit  (res_emit),
    .res       (res),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_window_digit   = out_res.window_digit;
  assign out_last_of_chunk  = out_res.last_of_chunk;
  assign out_last_of_scalar = out_res.last_of_scalar;

endmodule
